// ----- src/pswr_pkg.sv -----
package pswr_pkg;

   localparam int VALUE_W    = 32;
   localparam int FRAC_BITS  = 16;
   localparam int STEP_BITS  = 16;
   localparam int COEF_BITS  = 30;
   localparam int WALL_W     = 16;
   localparam int MASS_W     = 32;
   localparam int CMD_W      = 2;
   localparam int CSR_W      = 32;
   localparam int ADDR_W     = 5;

   // coefficients reach +2.0 in Q2.30, so they carry one extra bit
   localparam int COEF_W     = VALUE_W + 1;
   localparam int PROD_W     = COEF_W + VALUE_W;
   localparam int WIDE_W     = PROD_W + 1;

   // divider: dividend is a 34 bit value shifted up by COEF_BITS
   localparam int DIVX_W     = MASS_W + 2;
   localparam int DIVN_W     = DIVX_W + COEF_BITS;
   localparam int QUO_W      = VALUE_W;
   localparam int REM_W      = MASS_W + 2;
   localparam int SUM_W      = MASS_W + 1;

   localparam int REQ_DATA_W = STEP_BITS + MASS_W + 6 * VALUE_W;
   localparam int RSP_DATA_W = 6 * VALUE_W;

   typedef enum logic [CMD_W-1:0] {
      CMD_MOVE    = 2'd0,
      CMD_COLLIDE = 2'd1,
      CMD_LOAD    = 2'd2,
      CMD_NOP     = 2'd3
   } cmd_type;

   localparam logic [2:0] REG_MASS    = 3'd0;
   localparam logic [2:0] REG_ACCEL_X = 3'd1;
   localparam logic [2:0] REG_ACCEL_Y = 3'd2;
   localparam logic [2:0] REG_BX_LOW  = 3'd3;
   localparam logic [2:0] REG_BX_HIGH = 3'd4;
   localparam logic [2:0] REG_BY_LOW  = 3'd5;
   localparam logic [2:0] REG_BY_HIGH = 3'd6;

   typedef logic signed [VALUE_W-1:0] value_type;
   typedef logic signed [WIDE_W-1:0]  wide_type;

   // clamp a wide signed value into the signed value range
   function automatic value_type sat_value(wide_type x);
      wide_type hi;
      wide_type lo;
      hi = {{(WIDE_W-VALUE_W+1){1'b0}}, {(VALUE_W-1){1'b1}}};
      lo = ~hi;
      if (x > hi) begin
         return hi[VALUE_W-1:0];
      end else if (x < lo) begin
         return lo[VALUE_W-1:0];
      end
      return x[VALUE_W-1:0];
   endfunction

endpackage

// ----- src/particle_step_with_rebound.sv -----
// Point particle integrator with wall rebound and elastic collision.
// Input words (req_*) carry a command in tuser: move by a time step,
// collide with a partner particle, load position and velocity, or no-op.
// Every accepted word yields exactly one result word (rsp_*) holding the
// new position, velocity and, after a collide, the partner's velocity.
// Walls, acceleration and own mass are written over the csr_* APB port
// while no word is in flight, a rule for the user that the block itself
// does not enforce; pready is tied high, reads return registers.
// One word is worked at a time; req_tready is high only while idle.
// Load and no-op go from accept straight to the final step. Move runs
// four products on the shared multiplier, each followed by its add stage,
// and one rebound stage per axis. Collide runs the radix-2 divider to form
// three Q2.30 coefficients, then eight products on the same multiplier;
// with both masses zero it goes straight to the final step. A finished
// result sits in the output register, and the block returns to idle and
// takes the next word while it waits; if the receiver stalls and a second result is
// ready, the block holds in its final step until the register frees.
// Synchronous reset clears position and velocity to zero, loads
// the register defaults and drops any pending result.
module particle_step_with_rebound
   import pswr_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,

   input  logic                  req_tvalid,
   output logic                  req_tready,
   // step_size, partner_mass, partner_vel_x, partner_vel_y,
   // load_pos_x, load_pos_y, load_vel_x, load_vel_y
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // command
   input  logic [CMD_W-1:0]      req_tuser,

   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // out_pos_x, out_pos_y, out_vel_x, out_vel_y,
   // partner_new_vel_x, partner_new_vel_y
   output logic [RSP_DATA_W-1:0] rsp_tdata,

   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [ADDR_W-1:0]     csr_paddr,
   input  logic [CSR_W-1:0]      csr_pwdata,
   output logic [CSR_W-1:0]      csr_prdata,
   output logic                  csr_pready
);

   typedef enum logic [9:0] {
      ST_IDLE     = 10'b0000000001,
      ST_MV_MUL   = 10'b0000000010,
      ST_MV_ADD   = 10'b0000000100,
      ST_MV_RB    = 10'b0000001000,
      ST_CL_LOAD  = 10'b0000010000,
      ST_CL_DIV   = 10'b0000100000,
      ST_CL_STORE = 10'b0001000000,
      ST_CL_MUL   = 10'b0010000000,
      ST_CL_FIN   = 10'b0100000000,
      ST_DONE     = 10'b1000000000
   } state_type;

   localparam int DCNT_W = $clog2(QUO_W);

   localparam logic [1:0] PH_POS_X = 2'd0;
   localparam logic [1:0] PH_POS_Y = 2'd1;
   localparam logic [1:0] PH_VEL_X = 2'd2;
   localparam logic [1:0] PH_VEL_Y = 2'd3;

   localparam logic [1:0] DIV_A  = 2'd0;
   localparam logic [1:0] DIV_B  = 2'd1;
   localparam logic [1:0] DIV_BP = 2'd2;

   // input word fields
   logic [STEP_BITS-1:0] in_step_size;
   logic [MASS_W-1:0]    in_partner_mass;
   value_type            in_partner_vel_x;
   value_type            in_partner_vel_y;
   value_type            in_load_pos_x;
   value_type            in_load_pos_y;
   value_type            in_load_vel_x;
   value_type            in_load_vel_y;
   cmd_type              in_command;

   assign {in_load_vel_y, in_load_vel_x, in_load_pos_y, in_load_pos_x,
           in_partner_vel_y, in_partner_vel_x, in_partner_mass, in_step_size} = req_tdata;
   assign in_command = cmd_type'(req_tuser);

   // configuration registers
   logic [MASS_W-1:0]        mass_ff;
   value_type                accel_x_ff, accel_y_ff;
   logic signed [WALL_W-1:0] bx_low_ff, bx_high_ff, by_low_ff, by_high_ff;
   logic                     csr_wr;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         mass_ff    <= MASS_W'(1) << FRAC_BITS;
         accel_x_ff <= '0;
         accel_y_ff <= '0;
         bx_low_ff  <= '0;
         bx_high_ff <= WALL_W'(1023);
         by_low_ff  <= '0;
         by_high_ff <= WALL_W'(767);
      end else if (csr_wr) begin
         case (csr_paddr[ADDR_W-1:2])
            REG_MASS:    mass_ff    <= csr_pwdata[MASS_W-1:0];
            REG_ACCEL_X: accel_x_ff <= csr_pwdata[VALUE_W-1:0];
            REG_ACCEL_Y: accel_y_ff <= csr_pwdata[VALUE_W-1:0];
            REG_BX_LOW:  bx_low_ff  <= csr_pwdata[WALL_W-1:0];
            REG_BX_HIGH: bx_high_ff <= csr_pwdata[WALL_W-1:0];
            REG_BY_LOW:  by_low_ff  <= csr_pwdata[WALL_W-1:0];
            REG_BY_HIGH: by_high_ff <= csr_pwdata[WALL_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[ADDR_W-1:2])
         REG_MASS:    csr_prdata = CSR_W'(mass_ff);
         REG_ACCEL_X: csr_prdata = CSR_W'(accel_x_ff);
         REG_ACCEL_Y: csr_prdata = CSR_W'(accel_y_ff);
         REG_BX_LOW:  csr_prdata = CSR_W'(bx_low_ff);
         REG_BX_HIGH: csr_prdata = CSR_W'(bx_high_ff);
         REG_BY_LOW:  csr_prdata = CSR_W'(by_low_ff);
         REG_BY_HIGH: csr_prdata = CSR_W'(by_high_ff);
         default:     csr_prdata = '0;
      endcase
   end

   // control and particle state
   state_type           state_ff, state_in;
   logic [1:0]          phase_ff, phase_in;
   logic [1:0]          div_sel_ff, div_sel_in;
   logic [DCNT_W-1:0]   div_cnt_ff, div_cnt_in;
   logic [2:0]          mcnt_ff, mcnt_in;
   logic                rsp_valid_ff, rsp_valid_in;
   value_type           pos_x_ff, pos_x_in, pos_y_ff, pos_y_in;
   value_type           vel_x_ff, vel_x_in, vel_y_ff, vel_y_in;

   // per-item operands and datapath registers
   logic [STEP_BITS-1:0] st_ff, st_in;
   logic [MASS_W-1:0]    m2_ff, m2_in;
   value_type            v2x_ff, v2x_in, v2y_ff, v2y_in;
   logic [SUM_W-1:0]     sum_ff, sum_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   wide_type             acc_ff, acc_in;
   logic [REM_W-1:0]     rem_ff, rem_in;
   logic [QUO_W-1:0]     dsh_ff, dsh_in;
   logic signed [COEF_W-1:0] a_ff, a_in, b_ff, b_in, bp_ff, bp_in;
   value_type            pnx_ff, pnx_in, pny_ff, pny_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   // shared multiplier
   logic signed [COEF_W-1:0] mul_a;
   value_type                mul_b;
   logic signed [PROD_W-1:0] mul_p;
   value_type                v1_axis, v2_axis;

   always_comb begin
      v1_axis = mcnt_ff[1] ? vel_y_ff : vel_x_ff;
      v2_axis = mcnt_ff[1] ? v2y_ff : v2x_ff;
      if (state_ff == ST_MV_MUL) begin
         mul_a = COEF_W'($signed({1'b0, st_ff}));
         case (phase_ff)
            PH_POS_X: mul_b = vel_x_ff;
            PH_POS_Y: mul_b = vel_y_ff;
            PH_VEL_X: mul_b = accel_x_ff;
            default:  mul_b = accel_y_ff;
         endcase
      end else begin
         // partner terms first, own velocity terms in the upper half
         if (!mcnt_ff[2]) begin
            mul_a = mcnt_ff[0] ? bp_ff : -a_ff;
            mul_b = mcnt_ff[0] ? v1_axis : v2_axis;
         end else begin
            mul_a = mcnt_ff[0] ? b_ff : a_ff;
            mul_b = mcnt_ff[0] ? v2_axis : v1_axis;
         end
      end
      mul_p = mul_a * mul_b;
   end

   // datapath helpers
   logic signed [SUM_W:0]   diff_w;
   logic                    diff_neg;
   logic [DIVX_W-1:0]       div_x;
   logic [DIVN_W-1:0]       div_n;
   logic [REM_W-1:0]        trial;
   logic                    trial_ge;
   logic [COEF_W-1:0]       quo;
   value_type               mv_tgt, mv_res;
   value_type               rb_pos, rb_vel;
   logic signed [WALL_W-1:0] rb_lo, rb_hi;
   wide_type                rb_lo_w, rb_hi_w, rb_pos_w;
   value_type               rb_pos_new, rb_vel_new;
   logic [2:0]              pcnt;
   value_type               mix_res;

   always_comb begin
      diff_w   = $signed({2'b00, mass_ff}) - $signed({2'b00, m2_ff});
      diff_neg = diff_w[SUM_W];
      case (div_sel_ff)
         DIV_A:   div_x = diff_neg ? DIVX_W'(-diff_w) : DIVX_W'(diff_w);
         DIV_B:   div_x = DIVX_W'({m2_ff, 1'b0});
         default: div_x = DIVX_W'({mass_ff, 1'b0});
      endcase
      div_n    = DIVN_W'(div_x) << COEF_BITS;
      trial    = {rem_ff[REM_W-2:0], dsh_ff[QUO_W-1]};
      trial_ge = trial >= REM_W'(sum_ff);
      quo      = COEF_W'(dsh_ff);

      case (phase_ff)
         PH_POS_X: mv_tgt = pos_x_ff;
         PH_POS_Y: mv_tgt = pos_y_ff;
         PH_VEL_X: mv_tgt = vel_x_ff;
         default:  mv_tgt = vel_y_ff;
      endcase
      mv_res = sat_value(WIDE_W'(mv_tgt) + WIDE_W'(prod_ff >>> STEP_BITS));

      rb_pos   = phase_ff[0] ? pos_y_ff : pos_x_ff;
      rb_vel   = phase_ff[0] ? vel_y_ff : vel_x_ff;
      rb_lo    = phase_ff[0] ? by_low_ff : bx_low_ff;
      rb_hi    = phase_ff[0] ? by_high_ff : bx_high_ff;
      rb_lo_w  = WIDE_W'(rb_lo) <<< FRAC_BITS;
      rb_hi_w  = WIDE_W'(rb_hi) <<< FRAC_BITS;
      rb_pos_w = WIDE_W'(rb_pos);
      rb_pos_new = rb_pos;
      rb_vel_new = rb_vel;
      // mirror once; the low wall wins when both are crossed
      if (rb_pos_w < rb_lo_w) begin
         rb_pos_new = sat_value((rb_lo_w <<< 1) - rb_pos_w);
         rb_vel_new = sat_value(-WIDE_W'(rb_vel));
      end else if (rb_pos_w > rb_hi_w) begin
         rb_pos_new = sat_value((rb_hi_w <<< 1) - rb_pos_w);
         rb_vel_new = sat_value(-WIDE_W'(rb_vel));
      end

      pcnt    = mcnt_ff - 3'd1;
      mix_res = sat_value((acc_ff + WIDE_W'(prod_ff)) >>> COEF_BITS);
   end

   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      div_sel_in   = div_sel_ff;
      div_cnt_in   = div_cnt_ff;
      mcnt_in      = mcnt_ff;
      rsp_valid_in = rsp_valid_ff;
      pos_x_in     = pos_x_ff;
      pos_y_in     = pos_y_ff;
      vel_x_in     = vel_x_ff;
      vel_y_in     = vel_y_ff;
      st_in        = st_ff;
      m2_in        = m2_ff;
      v2x_in       = v2x_ff;
      v2y_in       = v2y_ff;
      sum_in       = sum_ff;
      prod_in      = prod_ff;
      acc_in       = acc_ff;
      rem_in       = rem_ff;
      dsh_in       = dsh_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      bp_in        = bp_ff;
      pnx_in       = pnx_ff;
      pny_in       = pny_ff;
      rsp_data_in  = rsp_data_ff;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      // fold the previous product: even terms seed, odd terms finish a sum
      if ((state_ff == ST_CL_MUL && mcnt_ff != 3'd0) || state_ff == ST_CL_FIN) begin
         if (!pcnt[0]) begin
            acc_in = WIDE_W'(prod_ff);
         end else begin
            case (pcnt[2:1])
               2'd0:    pnx_in   = mix_res;
               2'd1:    pny_in   = mix_res;
               2'd2:    vel_x_in = mix_res;
               default: vel_y_in = mix_res;
            endcase
         end
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               st_in      = in_step_size;
               m2_in      = in_partner_mass;
               v2x_in     = in_partner_vel_x;
               v2y_in     = in_partner_vel_y;
               sum_in     = {1'b0, mass_ff} + {1'b0, in_partner_mass};
               pnx_in     = '0;
               pny_in     = '0;
               phase_in   = PH_POS_X;
               div_sel_in = DIV_A;
               mcnt_in    = '0;
               case (in_command)
                  CMD_MOVE: state_in = ST_MV_MUL;
                  CMD_COLLIDE: begin
                     if (sum_in == '0) begin
                        pnx_in   = in_partner_vel_x;
                        pny_in   = in_partner_vel_y;
                        state_in = ST_DONE;
                     end else begin
                        state_in = ST_CL_LOAD;
                     end
                  end
                  CMD_LOAD: begin
                     pos_x_in = in_load_pos_x;
                     pos_y_in = in_load_pos_y;
                     vel_x_in = in_load_vel_x;
                     vel_y_in = in_load_vel_y;
                     state_in = ST_DONE;
                  end
                  default: state_in = ST_DONE;
               endcase
            end
         end
         ST_MV_MUL: begin
            prod_in  = mul_p;
            state_in = ST_MV_ADD;
         end
         ST_MV_ADD: begin
            case (phase_ff)
               PH_POS_X: pos_x_in = mv_res;
               PH_POS_Y: pos_y_in = mv_res;
               PH_VEL_X: vel_x_in = mv_res;
               default:  vel_y_in = mv_res;
            endcase
            if (phase_ff == PH_POS_X || phase_ff == PH_POS_Y) begin
               state_in = ST_MV_RB;
            end else if (phase_ff == PH_VEL_Y) begin
               state_in = ST_DONE;
            end else begin
               phase_in = phase_ff + 2'd1;
               state_in = ST_MV_MUL;
            end
         end
         ST_MV_RB: begin
            if (phase_ff[0]) begin
               pos_y_in = rb_pos_new;
               vel_y_in = rb_vel_new;
            end else begin
               pos_x_in = rb_pos_new;
               vel_x_in = rb_vel_new;
            end
            phase_in = phase_ff + 2'd1;
            state_in = ST_MV_MUL;
         end
         ST_CL_LOAD: begin
            rem_in     = REM_W'(div_n[DIVN_W-1:QUO_W]);
            dsh_in     = div_n[QUO_W-1:0];
            div_cnt_in = '0;
            state_in   = ST_CL_DIV;
         end
         ST_CL_DIV: begin
            rem_in     = trial_ge ? trial - REM_W'(sum_ff) : trial;
            dsh_in     = {dsh_ff[QUO_W-2:0], trial_ge};
            div_cnt_in = div_cnt_ff + 1'b1;
            if (div_cnt_ff == DCNT_W'(QUO_W - 1)) begin
               state_in = ST_CL_STORE;
            end
         end
         ST_CL_STORE: begin
            case (div_sel_ff)
               DIV_A:   a_in  = diff_neg ? -$signed(quo) : $signed(quo);
               DIV_B:   b_in  = $signed(quo);
               default: bp_in = $signed(quo);
            endcase
            if (div_sel_ff == DIV_BP) begin
               mcnt_in  = '0;
               state_in = ST_CL_MUL;
            end else begin
               div_sel_in = div_sel_ff + 2'd1;
               state_in   = ST_CL_LOAD;
            end
         end
         ST_CL_MUL: begin
            prod_in = mul_p;
            mcnt_in = mcnt_ff + 3'd1;
            if (mcnt_ff == 3'd7) begin
               state_in = ST_CL_FIN;
            end
         end
         ST_CL_FIN: state_in = ST_DONE;
         ST_DONE: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_data_in  = {pny_ff, pnx_ff, vel_y_ff, vel_x_ff, pos_y_ff, pos_x_ff};
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         phase_ff     <= PH_POS_X;
         div_sel_ff   <= DIV_A;
         div_cnt_ff   <= '0;
         mcnt_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         pos_x_ff     <= '0;
         pos_y_ff     <= '0;
         vel_x_ff     <= '0;
         vel_y_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         div_sel_ff   <= div_sel_in;
         div_cnt_ff   <= div_cnt_in;
         mcnt_ff      <= mcnt_in;
         rsp_valid_ff <= rsp_valid_in;
         pos_x_ff     <= pos_x_in;
         pos_y_ff     <= pos_y_in;
         vel_x_ff     <= vel_x_in;
         vel_y_ff     <= vel_y_in;
      end
   end

   always_ff @(posedge clock) begin
      st_ff       <= st_in;
      m2_ff       <= m2_in;
      v2x_ff      <= v2x_in;
      v2y_ff      <= v2y_in;
      sum_ff      <= sum_in;
      prod_ff     <= prod_in;
      acc_ff      <= acc_in;
      rem_ff      <= rem_in;
      dsh_ff      <= dsh_in;
      a_ff        <= a_in;
      b_ff        <= b_in;
      bp_ff       <= bp_in;
      pnx_ff      <= pnx_in;
      pny_ff      <= pny_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

`ifndef NO_ASSERTIONS
   a_rem_below_divisor: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CL_DIV) |-> (rem_ff < REM_W'(sum_ff)))
      else $error("divider remainder not below mass sum");

   a_load_takes_effect: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && in_command == CMD_LOAD)
      |=> (pos_x_ff == $past(in_load_pos_x) && vel_y_ff == $past(in_load_vel_y)))
      else $error("load did not set particle state");

   a_nop_keeps_state: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && in_command == CMD_NOP)
      |=> ($stable(pos_x_ff) && $stable(pos_y_ff) && $stable(vel_x_ff) && $stable(vel_y_ff)))
      else $error("no-op changed particle state");

   a_result_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(state_ff == ST_DONE))
      else $error("result raised outside the final step");
`endif

endmodule

// ----- test/tb_top.sv -----
module tb_top
   import pswr_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int     RUN_LIMIT   = 1_000_000;
   localparam int     LONG_HOLD   = 300;
   localparam int     WAIT_MAX    = 17;
   localparam int     PHASE_WORDS = 155;
   localparam int     RANDOM_PHASES = 8;
   localparam longint VAL_MAX     = 64'sd2147483647;
   localparam longint VAL_MIN     = -VAL_MAX - 1;

   // fields from the top bit down, so the low part lines up with req_tdata
   typedef struct packed {
      cmd_type     cmd;
      value_type   load_vy;
      value_type   load_vx;
      value_type   load_py;
      value_type   load_px;
      value_type   partner_vy;
      value_type   partner_vx;
      logic [31:0] partner_mass;
      logic [15:0] step;
   } particle_cmd_type;

   // same layout as rsp_tdata, out_pos_x in the lowest bits
   typedef struct packed {
      value_type partner_vy;
      value_type partner_vx;
      value_type vel_y;
      value_type vel_x;
      value_type pos_y;
      value_type pos_x;
   } particle_report_type;

   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  req_tvalid  = 1'b0;
   logic                  req_tready;
   // step_size, partner_mass, partner_vel_x, partner_vel_y,
   // load_pos_x, load_pos_y, load_vel_x, load_vel_y
   logic [REQ_DATA_W-1:0] req_tdata   = '0;
   // command
   logic [CMD_W-1:0]      req_tuser   = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready  = 1'b0;
   // out_pos_x, out_pos_y, out_vel_x, out_vel_y,
   // partner_new_vel_x, partner_new_vel_y
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_psel    = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite  = 1'b0;
   logic [ADDR_W-1:0]     csr_paddr   = '0;
   logic [CSR_W-1:0]      csr_pwdata  = '0;
   logic [CSR_W-1:0]      csr_prdata;
   logic                  csr_pready;

   particle_step_with_rebound i_dut (
      .clock,
      .reset,
      .req_tvalid,
      .req_tready,
      .req_tdata,
      .req_tuser,
      .rsp_tvalid,
      .rsp_tready,
      .rsp_tdata,
      .csr_psel,
      .csr_penable,
      .csr_pwrite,
      .csr_paddr,
      .csr_pwdata,
      .csr_prdata,
      .csr_pready
   );

   // predicted register copy and particle state
   logic [31:0] own_mass = 32'h0001_0000;
   longint accel_x_q16 = 0;
   longint accel_y_q16 = 0;
   longint wall_x_lo = 0;
   longint wall_x_hi = 1023;
   longint wall_y_lo = 0;
   longint wall_y_hi = 767;
   longint pos_x = 0;
   longint pos_y = 0;
   longint vel_x = 0;
   longint vel_y = 0;

   particle_cmd_type    queued_commands[$];
   particle_report_type expected_states[$];
   particle_cmd_type    cur_word;

   int  mismatches   = 0;
   int  results_seen = 0;
   int  cycles_run   = 0;
   bit  req_taken    = 1'b0;
   bit  rsp_taken    = 1'b0;
   bit  req_loaded   = 1'b0;
   bit  req_calm     = 1'b0;
   bit  rsp_calm     = 1'b0;
   int  req_gap      = 0;
   int  rsp_stall    = 0;
   int  rsp_hold     = 0;

   initial forever #5 clock = ~clock;

   function automatic longint clamp_value(longint x);
      if (x > VAL_MAX) return VAL_MAX;
      if (x < VAL_MIN) return VAL_MIN;
      return x;
   endfunction

   // mirror once at whichever wall was crossed, low wall first
   function automatic void bounce_off_walls(inout longint pos, inout longint vel,
                                            input longint lo_wall, input longint hi_wall);
      longint lo;
      longint hi;
      lo = lo_wall * 65536;
      hi = hi_wall * 65536;
      if (pos < lo) begin
         pos = clamp_value(2 * lo - pos);
         vel = clamp_value(-vel);
      end else if (pos > hi) begin
         pos = clamp_value(2 * hi - pos);
         vel = clamp_value(-vel);
      end
   endfunction

   function automatic longint blend_velocity(longint ca, longint va, longint cb, longint vb);
      return clamp_value((ca * va + cb * vb) >>> COEF_BITS);
   endfunction

   function automatic particle_report_type advance_particle(particle_cmd_type w);
      particle_report_type r;
      longint st, m1, m2, mass_sum, ca, cb, cbp;
      longint v1x, v1y, v2x, v2y, pnx, pny;
      pnx = 0;
      pny = 0;
      v2x = longint'(w.partner_vx);
      v2y = longint'(w.partner_vy);
      case (w.cmd)
         CMD_MOVE: begin
            st = longint'({48'd0, w.step});
            pos_x = clamp_value(pos_x + ((st * vel_x) >>> STEP_BITS));
            pos_y = clamp_value(pos_y + ((st * vel_y) >>> STEP_BITS));
            bounce_off_walls(pos_x, vel_x, wall_x_lo, wall_x_hi);
            bounce_off_walls(pos_y, vel_y, wall_y_lo, wall_y_hi);
            vel_x = clamp_value(vel_x + ((st * accel_x_q16) >>> STEP_BITS));
            vel_y = clamp_value(vel_y + ((st * accel_y_q16) >>> STEP_BITS));
         end
         CMD_COLLIDE: begin
            m1 = longint'({32'd0, own_mass});
            m2 = longint'({32'd0, w.partner_mass});
            mass_sum = m1 + m2;
            if (mass_sum == 0) begin
               // massless pair: partner passes through untouched
               pnx = v2x;
               pny = v2y;
            end else begin
               ca  = ((m1 - m2) <<< COEF_BITS) / mass_sum;
               cb  = ((2 * m2) <<< COEF_BITS) / mass_sum;
               cbp = ((2 * m1) <<< COEF_BITS) / mass_sum;
               v1x = vel_x;
               v1y = vel_y;
               vel_x = blend_velocity(ca, v1x, cb, v2x);
               vel_y = blend_velocity(ca, v1y, cb, v2y);
               pnx = blend_velocity(-ca, v2x, cbp, v1x);
               pny = blend_velocity(-ca, v2y, cbp, v1y);
            end
         end
         CMD_LOAD: begin
            pos_x = longint'(w.load_px);
            pos_y = longint'(w.load_py);
            vel_x = longint'(w.load_vx);
            vel_y = longint'(w.load_vy);
         end
         default: begin
         end
      endcase
      r.pos_x      = pos_x[VALUE_W-1:0];
      r.pos_y      = pos_y[VALUE_W-1:0];
      r.vel_x      = vel_x[VALUE_W-1:0];
      r.vel_y      = vel_y[VALUE_W-1:0];
      r.partner_vx = pnx[VALUE_W-1:0];
      r.partner_vy = pny[VALUE_W-1:0];
      return r;
   endfunction

   function automatic void compare_field(string name, value_type want, value_type got);
      if (got !== want) begin
         mismatches++;
         $error("%s: expected %h, actual %h", name, want, got);
      end
   endfunction

   function automatic int draw_wait(inout bit calm);
      if ($urandom_range(0, 29) == 0) calm = !calm;
      return calm ? 0 : $urandom_range(0, WAIT_MAX);
   endfunction

   function automatic value_type pick_speed();
      case ($urandom_range(0, 9))
         0: return $urandom;
         1: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
         default: return $signed($urandom) >>> $urandom_range(8, 24);
      endcase
   endfunction

   function automatic logic [31:0] pick_mass();
      case ($urandom_range(0, 19))
         0: return 32'h0000_0000;
         1: return 32'h0000_0001;
         2: return 32'hFFFF_FFFF;
         3, 4: return $urandom;
         default: return $urandom_range(32'h0000_4000, 32'h0004_0000);
      endcase
   endfunction

   // mostly inside the box, now and then anywhere
   function automatic value_type pick_position(longint lo_w, longint hi_w);
      longint span;
      span = (hi_w - lo_w + 1) * 65536;
      if (span <= 0 || $urandom_range(0, 7) == 0) return $urandom;
      return value_type'(lo_w * 65536 + longint'($urandom) % span);
   endfunction

   // every field carries content, the command decides what is used
   function automatic particle_cmd_type random_word();
      particle_cmd_type w;
      w.cmd          = CMD_NOP;
      w.step         = 16'($urandom);
      w.partner_mass = pick_mass();
      w.partner_vx   = pick_speed();
      w.partner_vy   = pick_speed();
      w.load_px      = pick_position(wall_x_lo, wall_x_hi);
      w.load_py      = pick_position(wall_y_lo, wall_y_hi);
      w.load_vx      = pick_speed();
      w.load_vy      = pick_speed();
      return w;
   endfunction

   task automatic queue_move(input logic [15:0] step);
      particle_cmd_type w;
      w = random_word();
      w.cmd = CMD_MOVE;
      w.step = step;
      queued_commands.push_back(w);
   endtask

   task automatic queue_collide(input logic [31:0] mass, input value_type vx,
                                input value_type vy);
      particle_cmd_type w;
      w = random_word();
      w.cmd = CMD_COLLIDE;
      w.partner_mass = mass;
      w.partner_vx = vx;
      w.partner_vy = vy;
      queued_commands.push_back(w);
   endtask

   task automatic queue_load(input value_type px, input value_type py,
                             input value_type vx, input value_type vy);
      particle_cmd_type w;
      w = random_word();
      w.cmd = CMD_LOAD;
      w.load_px = px;
      w.load_py = py;
      w.load_vx = vx;
      w.load_vy = vy;
      queued_commands.push_back(w);
   endtask

   task automatic queue_nop();
      particle_cmd_type w;
      w = random_word();
      w.cmd = CMD_NOP;
      queued_commands.push_back(w);
   endtask

   task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      case (idx)
         REG_MASS:    own_mass    = value;
         REG_ACCEL_X: accel_x_q16 = longint'($signed(value));
         REG_ACCEL_Y: accel_y_q16 = longint'($signed(value));
         REG_BX_LOW:  wall_x_lo   = longint'($signed(value[15:0]));
         REG_BX_HIGH: wall_x_hi   = longint'($signed(value[15:0]));
         REG_BY_LOW:  wall_y_lo   = longint'($signed(value[15:0]));
         REG_BY_HIGH: wall_y_hi   = longint'($signed(value[15:0]));
         default: begin
         end
      endcase
   endtask

   task automatic write_all_regs(input logic [31:0] mass, input logic [31:0] ax,
                                 input logic [31:0] ay, input int x_lo, input int x_hi,
                                 input int y_lo, input int y_hi);
      write_reg(REG_MASS, mass);
      write_reg(REG_ACCEL_X, ax);
      write_reg(REG_ACCEL_Y, ay);
      write_reg(REG_BX_LOW, 32'(x_lo));
      write_reg(REG_BX_HIGH, 32'(x_hi));
      write_reg(REG_BY_LOW, 32'(y_lo));
      write_reg(REG_BY_HIGH, 32'(y_hi));
   endtask

   task automatic set_phase_config(input int p);
      int x_lo, x_hi, y_lo, y_hi, t;
      if (p == 0) begin
         write_all_regs(32'h0000_0001, 32'h7FFF_FFFF, 32'h8000_0000,
                        -32768, 32767, 32767, -32768);
      end else if (p == RANDOM_PHASES - 1) begin
         write_all_regs(32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, -32768, 32767, 0, 767);
      end else begin
         x_lo = $urandom_range(0, 3000) - 1500;
         x_hi = x_lo + $urandom_range(0, 2000);
         y_lo = $urandom_range(0, 3000) - 1500;
         y_hi = y_lo + $urandom_range(0, 2000);
         if ($urandom_range(0, 5) == 0) begin
            t = x_lo;
            x_lo = x_hi;
            x_hi = t;
         end
         write_all_regs(pick_mass(), $signed($urandom) >>> $urandom_range(10, 30),
                        $signed($urandom) >>> $urandom_range(10, 30), x_lo, x_hi, y_lo, y_hi);
      end
   endtask

   // every word yields a result, so an empty store means the block is idle
   task automatic wait_drained();
      do @(negedge clock);
      while (queued_commands.size() != 0 || req_loaded || expected_states.size() != 0);
      repeat (4) @(negedge clock);
   endtask

   // sender
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_taken) begin
            req_loaded = 1'b0;
            req_gap = draw_wait(req_calm);
         end
         if (!req_loaded) begin
            if (req_gap > 0) begin
               req_gap--;
            end else if (queued_commands.size() != 0) begin
               cur_word = queued_commands.pop_front();
               req_tdata <= cur_word[REQ_DATA_W-1:0];
               req_tuser <= cur_word.cmd;
               req_loaded = 1'b1;
            end
         end
         req_tvalid <= req_loaded;
      end
   end

   // receiver
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_taken) begin
            rsp_stall = draw_wait(rsp_calm);
            // long back-pressure so the block fills and stalls its input
            if (results_seen == 150 || results_seen == 700) rsp_hold = LONG_HOLD;
         end
         if (rsp_hold > 0) begin
            rsp_hold--;
            rsp_tready <= 1'b0;
         end else if (rsp_stall > 0) begin
            rsp_stall--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // handshakes: check results, predict accepted words
   always @(posedge clock) begin
      particle_report_type got;
      particle_report_type want;
      if (reset) begin
         req_taken = 1'b0;
         rsp_taken = 1'b0;
      end else begin
         rsp_taken = rsp_tvalid && rsp_tready;
         if (rsp_taken) begin
            results_seen++;
            got = particle_report_type'(rsp_tdata);
            if (expected_states.size() == 0) begin
               mismatches++;
               $error("result word arrived with none expected: %h", rsp_tdata);
            end else begin
               want = expected_states.pop_front();
               compare_field("out_pos_x", want.pos_x, got.pos_x);
               compare_field("out_pos_y", want.pos_y, got.pos_y);
               compare_field("out_vel_x", want.vel_x, got.vel_x);
               compare_field("out_vel_y", want.vel_y, got.vel_y);
               compare_field("partner_new_vel_x", want.partner_vx, got.partner_vx);
               compare_field("partner_new_vel_y", want.partner_vy, got.partner_vy);
            end
         end
         req_taken = req_tvalid && req_tready;
         if (req_taken) expected_states.push_back(advance_particle(cur_word));
      end
   end

   always @(posedge clock) begin
      cycles_run++;
      if (cycles_run > RUN_LIMIT) begin
         $display("[particle_step_with_rebound] ERROR");
         $finish;
      end
   end

   initial begin
      particle_cmd_type w;
      int r;
      repeat (8) @(negedge clock);
      reset <= 1'b0;

      // register defaults: box 0..1023 by 0..767, unit mass, no acceleration
      queue_nop();
      queue_load(32'h0064_0000, 32'h00C8_0000, 32'h0003_8000, 32'hFFFD_C000);
      queue_move(16'hFFFF);
      queue_move(16'h0000);
      queue_load(32'h0001_0000, 32'h02FE_0000, 32'hFFF6_0000, 32'h000A_0000);
      queue_move(16'h8000);
      // far crossing, mirrored once; most negative speed negates with saturation
      queue_load(32'h0000_0000, 32'h0000_0000, 32'h8000_0000, 32'h7FFF_FFFF);
      queue_move(16'hFFFF);
      queue_load(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
      queue_move(16'hFFFF);
      queue_load(32'h0010_0000, 32'h0010_0000, 32'h0002_0000, 32'hFFFF_0000);
      queue_collide(32'h0001_0000, 32'h0005_0000, 32'hFFF9_0000);
      queue_collide(32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
      queue_collide(32'h0000_0001, 32'h8000_0000, 32'h7FFF_FFFF);
      queue_nop();
      wait_drained();

      // low x wall above high x wall, extreme acceleration and mass
      write_all_regs(32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 100, -100, -32768, 32767);
      queue_load(32'h0032_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
      queue_move(16'hFFFF);
      queue_move(16'hFFFF);
      queue_load(32'h0096_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
      queue_move(16'h0000);
      queue_collide(32'hFFFF_FFFF, 32'h0003_0000, 32'hFFFC_0000);
      queue_collide(32'h0000_0001, 32'h7FFF_FFFF, 32'h0001_0000);
      wait_drained();

      // zero own mass, including a massless pair
      write_reg(REG_MASS, 32'h0000_0000);
      queue_collide(32'h0000_0000, 32'h0003_0000, 32'hFFFC_0000);
      queue_collide(32'hFFFF_FFFF, 32'h0002_0000, 32'h8000_0000);
      queue_move(16'h1234);
      wait_drained();

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         set_phase_config(p);
         for (int i = 0; i < PHASE_WORDS; i++) begin
            w = random_word();
            r = $urandom_range(0, 19);
            if (r < 12) begin
               w.cmd = CMD_MOVE;
            end else if (r < 15) begin
               w.cmd = CMD_COLLIDE;
            end else if (r < 19) begin
               w.cmd = CMD_LOAD;
            end else begin
               w.cmd = CMD_NOP;
            end
            if ($urandom_range(0, 3) != 0) w.step = 16'($urandom_range(0, 16'h0800));
            queued_commands.push_back(w);
         end
         wait_drained();
      end

      repeat (20) @(negedge clock);
      if (mismatches == 0 && expected_states.size() == 0) begin
         $display("[particle_step_with_rebound] OK");
      end else begin
         $display("[particle_step_with_rebound] ERROR");
      end
      $finish;
   end

endmodule
